[rtl/gcwp_pkg.sv]
`timescale 1ns / 1ps
// gcwp_pkg: types, constants and the power-of-ten table shared by the
// coordinate word parser modules; no dependencies

package gcwp_pkg;

  localparam int unsigned IuPerMm    = 100000;
  localparam int unsigned MaxDigits  = 12;
  localparam int unsigned ScaleSteps = 9;
  localparam int unsigned MantW      = 40;
  localparam int unsigned VW         = 68;
  localparam int unsigned LimbW      = 17;
  localparam int unsigned MaxDivExp  = 20;

  localparam logic [2:0] AxisX = 3'd0;
  localparam logic [2:0] AxisY = 3'd1;
  localparam logic [2:0] AxisA = 3'd2;
  localparam logic [2:0] AxisI = 3'd3;
  localparam logic [2:0] AxisJ = 3'd4;

  localparam logic [1:0] ArcNone   = 2'd0;
  localparam logic [1:0] ArcRadius = 2'd1;
  localparam logic [1:0] ArcCenter = 2'd2;

  localparam logic [3:0] RegFracX = 4'd0;
  localparam logic [3:0] RegFracY = 4'd1;
  localparam logic [3:0] RegLenX  = 4'd2;
  localparam logic [3:0] RegLenY  = 4'd3;
  localparam logic [3:0] RegMetric = 4'd4;
  localparam logic [3:0] RegOtz    = 4'd5;
  localparam logic [3:0] RegRel    = 4'd6;
  localparam logic [3:0] RegExc    = 4'd7;

  typedef struct packed {
    logic [7:0] char_code;
    logic       end_of_text;
  } in_item_t;

  typedef struct packed {
    logic [2:0]         word_axis;
    logic signed [31:0] word_value;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] center_x;
    logic signed [31:0] center_y;
    logic signed [31:0] arc_radius;
    logic [1:0]         arc_kind;
  } out_item_t;

  typedef struct packed {
    logic [2:0]       letter;
    logic [MantW-1:0] mantissa;
    logic             negative;
    logic [3:0]       ndigits;
    logic [3:0]       fraction_count;
    logic             decimal;
    logic             clear_ij;
  } word_t;

  typedef struct packed {
    logic [3:0] frac_x;
    logic [3:0] frac_y;
    logic [3:0] len_x;
    logic [3:0] len_y;
    logic       metric;
    logic       otz;
    logic       rel;
    logic       exc;
  } cfg_t;

  function automatic logic [VW-1:0] pow10(input logic [4:0] k);
    logic [VW-1:0] r;
    unique case (k)
      5'd1:  r = 68'd10;
      5'd2:  r = 68'd100;
      5'd3:  r = 68'd1000;
      5'd4:  r = 68'd10000;
      5'd5:  r = 68'd100000;
      5'd6:  r = 68'd1000000;
      5'd7:  r = 68'd10000000;
      5'd8:  r = 68'd100000000;
      5'd9:  r = 68'd1000000000;
      5'd10: r = 68'd10000000000;
      5'd11: r = 68'd100000000000;
      5'd12: r = 68'd1000000000000;
      5'd13: r = 68'd10000000000000;
      5'd14: r = 68'd100000000000000;
      5'd15: r = 68'd1000000000000000;
      5'd16: r = 68'd10000000000000000;
      5'd17: r = 68'd100000000000000000;
      5'd18: r = 68'd1000000000000000000;
      5'd19: r = 68'd10000000000000000000;
      5'd20: r = 68'd100000000000000000000;
      default: r = 68'd1;
    endcase
    return r;
  endfunction

endpackage

[rtl/gcwp_front.sv]
`timescale 1ns / 1ps
// gcwp_front: character front end, tracks the open word and its group
// and hands finished words to the queue; uses gcwp_pkg

module gcwp_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  gcwp_pkg::in_item_t in_item_i,
  input  logic              q_full_i,
  output logic              push_o,
  output gcwp_pkg::word_t   rec_o
);

  logic                        in_word_q, in_word_d;
  logic [2:0]                  letter_q, letter_d;
  logic [gcwp_pkg::MantW-1:0]  mant_q, mant_d;
  logic                        neg_q, neg_d;
  logic [3:0]                  dcnt_q, dcnt_d;
  logic [3:0]                  fcnt_q, fcnt_d;
  logic                        dseen_q, dseen_d;
  logic                        gdec_q, gdec_d;
  logic                        clr_q, clr_d;

  logic [7:0]  c;
  logic        eot, acc, is_letter, is_num, is_digit, cont;
  logic [2:0]  axis;
  logic [43:0] prod, sum;
  logic [gcwp_pkg::MantW-1:0] a_mant;
  logic        a_neg, a_dseen, a_gdec;
  logic [3:0]  a_dcnt, a_fcnt;

  assign c   = in_item_i.char_code;
  assign eot = in_item_i.end_of_text;
  assign in_ready_o = !q_full_i;
  assign acc = in_valid_i && in_ready_o;

  always_comb begin
    is_letter = 1'b1;
    axis = gcwp_pkg::AxisX;
    unique case (c)
      8'h58: axis = gcwp_pkg::AxisX;
      8'h59: axis = gcwp_pkg::AxisY;
      8'h41: axis = gcwp_pkg::AxisA;
      8'h49: axis = gcwp_pkg::AxisI;
      8'h4A: axis = gcwp_pkg::AxisJ;
      default: is_letter = 1'b0;
    endcase
  end

  assign is_digit = (c >= 8'h30) && (c <= 8'h39);
  assign is_num   = is_digit || c == 8'h2B || c == 8'h2D || c == 8'h2E;
  assign cont     = in_word_q && ((letter_q >= gcwp_pkg::AxisI) == (axis >= gcwp_pkg::AxisI));

  // digit, point and sign accumulation
  always_comb begin
    prod    = {1'b0, mant_q, 3'b000} + {3'b000, mant_q, 1'b0};
    sum     = prod + {40'd0, c[3:0]};
    a_mant  = mant_q;
    a_neg   = neg_q;
    a_dcnt  = dcnt_q;
    a_fcnt  = fcnt_q;
    a_dseen = dseen_q;
    a_gdec  = gdec_q;
    if (is_digit) begin
      if (32'(dcnt_q) < gcwp_pkg::MaxDigits && sum[43:40] == 4'd0) begin
        a_mant = sum[39:0];
        if (dseen_q) a_fcnt = fcnt_q + 4'd1;
      end else if (!dseen_q) begin
        a_mant = (prod[43:40] != 4'd0) ? {gcwp_pkg::MantW{1'b1}} : prod[39:0];
      end
      if (dcnt_q != 4'd15) a_dcnt = dcnt_q + 4'd1;
    end else if (c == 8'h2E) begin
      if (!dseen_q) begin
        a_dseen = 1'b1;
        a_gdec  = 1'b1;
      end
    end else if (dcnt_q == 4'd0 && !dseen_q) begin
      a_neg = (c == 8'h2D);
    end
  end

  always_comb begin
    in_word_d = in_word_q;
    letter_d  = letter_q;
    mant_d    = mant_q;
    neg_d     = neg_q;
    dcnt_d    = dcnt_q;
    fcnt_d    = fcnt_q;
    dseen_d   = dseen_q;
    gdec_d    = gdec_q;
    clr_d     = clr_q;
    push_o    = 1'b0;
    rec_o     = '{letter: letter_q, mantissa: mant_q, negative: neg_q,
                  ndigits: dcnt_q, fraction_count: fcnt_q,
                  decimal: dseen_q | gdec_q, clear_ij: clr_q};
    if (acc) begin
      if (is_letter) begin
        push_o = in_word_q;
        if (!cont) gdec_d = 1'b0;
        if (eot) begin
          in_word_d = 1'b0;
          gdec_d    = 1'b0;
        end else begin
          clr_d     = (axis >= gcwp_pkg::AxisI) && !cont;
          in_word_d = 1'b1;
          letter_d  = axis;
          mant_d    = '0;
          neg_d     = 1'b0;
          dcnt_d    = 4'd0;
          fcnt_d    = 4'd0;
          dseen_d   = 1'b0;
        end
      end else if (in_word_q && is_num) begin
        mant_d  = a_mant;
        neg_d   = a_neg;
        dcnt_d  = a_dcnt;
        fcnt_d  = a_fcnt;
        dseen_d = a_dseen;
        gdec_d  = a_gdec;
        if (eot) begin
          push_o = 1'b1;
          rec_o  = '{letter: letter_q, mantissa: a_mant, negative: a_neg,
                     ndigits: a_dcnt, fraction_count: a_fcnt,
                     decimal: a_dseen | a_gdec, clear_ij: clr_q};
          in_word_d = 1'b0;
          gdec_d    = 1'b0;
        end
      end else begin
        if (in_word_q) begin
          push_o    = 1'b1;
          in_word_d = 1'b0;
        end
        if (!is_num || eot) gdec_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_word_q <= 1'b0;
      letter_q  <= '0;
      mant_q    <= '0;
      neg_q     <= 1'b0;
      dcnt_q    <= '0;
      fcnt_q    <= '0;
      dseen_q   <= 1'b0;
      gdec_q    <= 1'b0;
      clr_q     <= 1'b0;
    end else begin
      in_word_q <= in_word_d;
      letter_q  <= letter_d;
      mant_q    <= mant_d;
      neg_q     <= neg_d;
      dcnt_q    <= dcnt_d;
      fcnt_q    <= fcnt_d;
      dseen_q   <= dseen_d;
      gdec_q    <= gdec_d;
      clr_q     <= clr_d;
    end
  end

endmodule

[rtl/gcwp_queue.sv]
`timescale 1ns / 1ps
// gcwp_queue: two-entry queue of finished words between front and back
// uses gcwp_pkg

module gcwp_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  gcwp_pkg::word_t rec_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            valid_o,
  output gcwp_pkg::word_t rec_o
);

  gcwp_pkg::word_t mem_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;

  assign full_o  = cnt_q[1];
  assign valid_o = cnt_q != 2'd0;
  assign rec_o   = mem_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wp_q] <= rec_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) wp_q <= !wp_q;
      if (pop_i) rp_q <= !rp_q;
      cnt_q <= cnt_q + {1'b0, push_i} - {1'b0, pop_i};
    end
  end

endmodule

[rtl/gcwp_back.sv]
`timescale 1ns / 1ps
// gcwp_back: configuration registers, word conversion sequencer and
// position state with the result register; uses gcwp_pkg

module gcwp_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [3:0]         cfg_idx_i,
  input  logic [3:0]         cfg_data_i,
  input  logic               q_valid_i,
  input  gcwp_pkg::word_t    q_rec_i,
  output logic               q_pop_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output gcwp_pkg::out_item_t out_item_o
);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_MLO   = 6'b000010,
    S_MHI   = 6'b000100,
    S_SCALE = 6'b001000,
    S_DIV   = 6'b010000,
    S_OUT   = 6'b100000
  } state_e;

  state_e state_q, state_d;
  gcwp_pkg::cfg_t cfg_q;
  gcwp_pkg::word_t rec_q;
  logic signed [5:0] e_q;
  logic [gcwp_pkg::VW-1:0] v_q;
  logic [3:0] div_r_q;
  logic ovf_q;
  logic [6:0] cnt_q;
  logic [31:0] cx_q, cy_q, ijx_q, ijy_q, rad_q;
  logic [1:0] kind_q;
  logic out_valid_q;
  gcwp_pkg::out_item_t out_q;

  logic [24:0] s;
  logic [44:0] pm;
  logic xaxis;
  logic signed [5:0] f, len, n, pad, e;
  logic [4:0] k;
  logic [3:0]  r_in, dr;
  logic [20:0] dt, dmul;
  logic [52:0] dp;
  logic [16:0] dq;
  logic [31:0] limit, mag, val, ijx_t, ijy_t;
  logic big, load;

  assign s  = cfg_q.metric ? 25'(gcwp_pkg::IuPerMm) : 25'(gcwp_pkg::IuPerMm * 254);
  assign pm = (state_q == S_MLO) ? 45'(rec_q.mantissa[19:0]) * 45'(s)
                                 : 45'(rec_q.mantissa[39:20]) * 45'(s);

  // decimal exponent of the word
  always_comb begin
    xaxis = q_rec_i.letter == gcwp_pkg::AxisX || q_rec_i.letter == gcwp_pkg::AxisI;
    f = xaxis ? {2'b00, cfg_q.frac_x} : {2'b00, cfg_q.frac_y};
    if (f > 6'(gcwp_pkg::ScaleSteps - 1)) f = 6'(gcwp_pkg::ScaleSteps - 1);
    len = xaxis ? {2'b00, cfg_q.len_x} : {2'b00, cfg_q.len_y};
    n   = {2'b00, q_rec_i.ndigits};
    pad = 6'sd0;
    if (cfg_q.otz && (n < len || (cfg_q.exc && q_rec_i.letter <= gcwp_pkg::AxisA && n > len)))
      pad = len - n;
    e = q_rec_i.decimal ? -{2'b00, q_rec_i.fraction_count} : pad - f;
    if (!cfg_q.metric) e = e - 6'sd1;
  end

  assign k = 5'(-e_q);

  // divide by ten, one limb per cycle, top limb first
  always_comb begin
    r_in = (cnt_q[1:0] == 2'd0) ? 4'd0 : div_r_q;
    dt   = {r_in, v_q[gcwp_pkg::VW-1 -: gcwp_pkg::LimbW]};
    dp   = 53'(dt) * 53'(32'hCCCC_CCCD);
    dq   = dp[51:35];
    dmul = {1'b0, dq, 3'b000} + {3'b000, dq, 1'b0};
    dr   = 4'(dt - dmul);
  end

  always_comb begin
    limit = rec_q.negative ? 32'h8000_0000 : 32'h7FFF_FFFF;
    big   = ovf_q || (v_q[gcwp_pkg::VW-1:32] != '0) || (v_q[31:0] > limit);
    mag   = big ? limit : v_q[31:0];
    val   = rec_q.negative ? (32'd0 - mag) : mag;
    ijx_t = rec_q.clear_ij ? 32'd0 : ijx_q;
    ijy_t = rec_q.clear_ij ? 32'd0 : ijy_q;
  end

  assign load = (state_q == S_OUT) && (!out_valid_q || out_ready_i);

  function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [31:0] b);
    logic signed [32:0] t;
    t = $signed({a[31], a}) + $signed({b[31], b});
    if (t > 33'sh0_7FFF_FFFF) return 32'h7FFF_FFFF;
    else if (t < -33'sh0_8000_0000) return 32'h8000_0000;
    else return t[31:0];
  endfunction

  always_comb begin
    state_d = state_q;
    q_pop_o = 1'b0;
    unique case (state_q)
      S_IDLE:  if (q_valid_i) begin
        q_pop_o = 1'b1;
        state_d = S_MLO;
      end
      S_MLO:   state_d = S_MHI;
      S_MHI:   begin
        if (e_q >= 0) state_d = S_SCALE;
        else if (k > 5'(gcwp_pkg::MaxDivExp)) state_d = S_OUT;
        else state_d = S_DIV;
      end
      S_SCALE: if (cnt_q == 7'd0) state_d = S_OUT;
      S_DIV:   if (cnt_q == 7'd1) state_d = S_OUT;
      S_OUT:   if (!out_valid_q || out_ready_i) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      S_IDLE: begin
        rec_q <= q_rec_i;
        e_q   <= e;
        ovf_q <= 1'b0;
      end
      S_MLO: v_q <= 68'(pm);
      S_MHI: begin
        if (e_q >= 0) begin
          v_q   <= v_q + {pm, 20'd0};
          cnt_q <= 7'(e_q);
        end else if (k > 5'(gcwp_pkg::MaxDivExp)) begin
          v_q <= '0;
        end else begin
          v_q   <= v_q + {pm, 20'd0} + (gcwp_pkg::pow10(k) >> 1);
          cnt_q <= {k, 2'b00};
        end
      end
      S_SCALE: if (cnt_q != 7'd0) begin
        if (v_q[gcwp_pkg::VW-1:32] != '0) ovf_q <= 1'b1;
        v_q   <= {v_q[gcwp_pkg::VW-4:0], 3'b000} + {v_q[gcwp_pkg::VW-2:0], 1'b0};
        cnt_q <= cnt_q - 7'd1;
      end
      S_DIV: begin
        // four limbs per decimal digit, quotient rotates in from the bottom
        v_q     <= {v_q[gcwp_pkg::VW-gcwp_pkg::LimbW-1:0], dq};
        div_r_q <= dr;
        cnt_q   <= cnt_q - 7'd1;
      end
      S_OUT: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cfg_q       <= '{frac_x: 4'd4, frac_y: 4'd4, len_x: 4'd6, len_y: 4'd6,
                       metric: 1'b0, otz: 1'b0, rel: 1'b0, exc: 1'b0};
      cx_q        <= '0;
      cy_q        <= '0;
      ijx_q       <= '0;
      ijy_q       <= '0;
      rad_q       <= '0;
      kind_q      <= gcwp_pkg::ArcNone;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          gcwp_pkg::RegFracX:  cfg_q.frac_x <= cfg_data_i;
          gcwp_pkg::RegFracY:  cfg_q.frac_y <= cfg_data_i;
          gcwp_pkg::RegLenX:   cfg_q.len_x  <= cfg_data_i;
          gcwp_pkg::RegLenY:   cfg_q.len_y  <= cfg_data_i;
          gcwp_pkg::RegMetric: cfg_q.metric <= cfg_data_i[0];
          gcwp_pkg::RegOtz:    cfg_q.otz    <= cfg_data_i[0];
          gcwp_pkg::RegRel:    cfg_q.rel    <= cfg_data_i[0];
          gcwp_pkg::RegExc:    cfg_q.exc    <= cfg_data_i[0];
          default: ;
        endcase
      end
      if (load) begin
        logic [31:0] nx, ny, nijx, nijy, nrad;
        logic [1:0]  nkind;
        nx = cx_q; ny = cy_q; nijx = ijx_t; nijy = ijy_t; nrad = rad_q; nkind = kind_q;
        unique case (rec_q.letter)
          gcwp_pkg::AxisX: nx = cfg_q.rel ? sat_add(cx_q, val) : val;
          gcwp_pkg::AxisY: ny = cfg_q.rel ? sat_add(cy_q, val) : val;
          gcwp_pkg::AxisA: begin
            nrad  = val;
            nkind = gcwp_pkg::ArcRadius;
          end
          gcwp_pkg::AxisI: begin
            nijx  = val;
            nkind = gcwp_pkg::ArcCenter;
          end
          default: begin
            nijy  = val;
            nkind = gcwp_pkg::ArcCenter;
          end
        endcase
        cx_q <= nx; cy_q <= ny; ijx_q <= nijx; ijy_q <= nijy; rad_q <= nrad;
        kind_q <= nkind;
        out_valid_q <= 1'b1;
        out_q <= '{word_axis: rec_q.letter, word_value: val, pos_x: nx, pos_y: ny,
                   center_x: nijx, center_y: nijy, arc_radius: nrad, arc_kind: nkind};
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

[rtl/gerber_coordinate_word_parser_top.sv]
`timescale 1ns / 1ps
// gerber_coordinate_word_parser_top: character front end, word queue and
// conversion back end; uses gcwp_pkg, gcwp_front, gcwp_queue, gcwp_back

// Characters are taken one per cycle while the two-entry word queue has
// room; a character that closes a word places it in the queue. The back end
// converts one word at a time: it takes the word from the queue, forms the
// partial-product multiply in a low and a high half, then either scales up
// by one power of ten per step (up to 15 powers), or divides by ten once per
// power of ten, one limb at a time (up to 20 powers; beyond that the value is
// zero with no division), then updates the position and loads the result
// register, which may wait for out_ready_i. The next word is taken from the
// queue only after that load.

module gerber_coordinate_word_parser_top (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  gcwp_pkg::in_item_t  in_item_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output gcwp_pkg::out_item_t out_item_o,
  input  logic                cfg_we_i,
  input  logic [3:0]          cfg_idx_i,
  input  logic [3:0]          cfg_data_i
);

  logic push, full, pop, qvalid;
  gcwp_pkg::word_t wr_rec, rd_rec;

  gcwp_front u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .in_item_i,
    .q_full_i(full), .push_o(push), .rec_o(wr_rec)
  );

  gcwp_queue u_queue (
    .clk_i, .rst_ni, .push_i(push), .rec_i(wr_rec), .full_o(full),
    .pop_i(pop), .valid_o(qvalid), .rec_o(rd_rec)
  );

  gcwp_back u_back (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .q_valid_i(qvalid), .q_rec_i(rd_rec), .q_pop_o(pop),
    .out_valid_o, .out_ready_i, .out_item_o
  );

endmodule

[verif/testbench.sv]
`timescale 1ns / 1ps
// testbench: self-checking bench for gerber_coordinate_word_parser_top,
// driving text characters and comparing each word against a built-in predictor
// depends on gcwp_pkg and the top-level RTL

module testbench;

  localparam longint unsigned MantMax = 64'hFF_FFFF_FFFF;
  localparam int CycleLimit = 600000;

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      in_valid_i = 1'b0;
  logic      in_ready_o;
  gcwp_pkg::in_item_t  in_item_i = '0;
  logic      out_valid_o;
  logic      out_ready_i = 1'b0;
  gcwp_pkg::out_item_t out_item_o;
  logic      cfg_we_i = 1'b0;
  logic [3:0] cfg_idx_i = '0;
  logic [3:0] cfg_data_i = '0;

  gerber_coordinate_word_parser_top u_dut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // predictor configuration and state
  gcwp_pkg::cfg_t cfg;
  bit          open_word, neg, point_seen, grp_point;
  logic [2:0]  letter;
  logic [63:0] mant;
  int          ndig, nfrac;
  logic [31:0] px, py, cx, cy, rad;
  logic [1:0]  kind;

  gcwp_pkg::out_item_t words_due[$];
  bit          typed_pending;
  logic [31:0] typed_value;
  int          errors = 0;
  int          cycles = 0;
  bit          quiet;

  function automatic logic [31:0] word_to_iu();
    logic [127:0] v;
    logic [31:0]  limit, mag;
    bit           xaxis;
    int           e, f, len;
    xaxis = (letter == gcwp_pkg::AxisX) || (letter == gcwp_pkg::AxisI);
    v = 128'(mant) * (cfg.metric ? 128'(gcwp_pkg::IuPerMm) : 128'(gcwp_pkg::IuPerMm) * 254);
    if (point_seen || grp_point) begin
      e = -nfrac;
    end else begin
      f = xaxis ? cfg.frac_x : cfg.frac_y;
      if (f > gcwp_pkg::ScaleSteps - 1) f = gcwp_pkg::ScaleSteps - 1;
      e = -f;
      if (cfg.otz) begin
        len = xaxis ? cfg.len_x : cfg.len_y;
        if (ndig < len || (cfg.exc && letter <= gcwp_pkg::AxisA && ndig > len))
          e += len - ndig;
      end
    end
    if (!cfg.metric) e -= 1;
    if (e >= 0) begin
      for (int i = 0; i < e; i++) v = v * 10;
    end else begin
      for (int i = 1; i < -e; i++) v = v / 10;
      v = (v + 5) / 10;
    end
    limit = neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
    mag = (v > 128'(limit)) ? limit : v[31:0];
    return neg ? -mag : mag;
  endfunction

  function automatic logic [31:0] sat_sum(logic [31:0] a, logic [31:0] b);
    longint s;
    s = longint'($signed(a)) + longint'($signed(b));
    if (s > 64'sd2147483647) s = 64'sd2147483647;
    if (s < -64'sd2147483648) s = -64'sd2147483648;
    return s[31:0];
  endfunction

  task automatic close_word();
    logic [31:0] val;
    gcwp_pkg::out_item_t r;
    val = word_to_iu();
    case (letter)
      gcwp_pkg::AxisX: px = cfg.rel ? sat_sum(px, val) : val;
      gcwp_pkg::AxisY: py = cfg.rel ? sat_sum(py, val) : val;
      gcwp_pkg::AxisA: begin
        rad = val;
        kind = gcwp_pkg::ArcRadius;
      end
      gcwp_pkg::AxisI: begin
        cx = val;
        kind = gcwp_pkg::ArcCenter;
      end
      default: begin
        cy = val;
        kind = gcwp_pkg::ArcCenter;
      end
    endcase
    r = '{letter, val, px, py, cx, cy, rad, kind};
    if (typed_pending) begin
      r.word_value = typed_value;
      typed_pending = 1'b0;
    end
    words_due = {words_due, r};
  endtask

  task automatic add_char(logic [7:0] c);
    logic [63:0] d;
    if (c >= "0" && c <= "9") begin
      d = 64'(c - "0");
      if (ndig < gcwp_pkg::MaxDigits && mant * 10 + d <= MantMax) begin
        mant = mant * 10 + d;
        if (point_seen) nfrac = (nfrac + 1) & 15;
      end else if (!point_seen) begin
        mant = (mant * 10 > MantMax) ? MantMax : mant * 10;
      end
      if (ndig < 15) ndig++;
    end else if (c == ".") begin
      if (!point_seen) begin
        point_seen = 1'b1;
        grp_point = 1'b1;
      end
    end else if (ndig == 0 && !point_seen) begin
      neg = (c == "-");
    end
  endtask

  task automatic predict_char(logic [7:0] c, bit eot);
    int  ltr;
    bit  same_grp, is_num;
    is_num = (c >= "0" && c <= "9") || c == "+" || c == "-" || c == ".";
    case (c)
      "X": ltr = gcwp_pkg::AxisX;
      "Y": ltr = gcwp_pkg::AxisY;
      "A": ltr = gcwp_pkg::AxisA;
      "I": ltr = gcwp_pkg::AxisI;
      "J": ltr = gcwp_pkg::AxisJ;
      default: ltr = -1;
    endcase
    if (ltr >= 0) begin
      same_grp = open_word && ((letter >= gcwp_pkg::AxisI) == (ltr >= gcwp_pkg::AxisI));
      if (open_word) close_word();
      if (!same_grp) grp_point = 1'b0;
      if (eot) begin
        open_word = 1'b0;
        grp_point = 1'b0;
      end else begin
        if (ltr >= gcwp_pkg::AxisI && !same_grp) begin
          cx = '0;
          cy = '0;
        end
        open_word = 1'b1;
        letter = ltr[2:0];
        mant = '0;
        neg = 1'b0;
        ndig = 0;
        nfrac = 0;
        point_seen = 1'b0;
      end
    end else if (open_word && is_num) begin
      add_char(c);
      if (eot) begin
        close_word();
        open_word = 1'b0;
        grp_point = 1'b0;
      end
    end else begin
      if (open_word) begin
        close_word();
        open_word = 1'b0;
      end
      if (!is_num || eot) grp_point = 1'b0;
    end
  endtask

  task automatic send_char(logic [7:0] c, bit eot);
    int gap;
    gap = quiet ? 0 : (($urandom_range(0, 9) == 0) ? $urandom_range(5, 40)
                                                   : $urandom_range(0, 2));
    predict_char(c, eot);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i  <= '{c, eot};
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic send_text(string s, bit has_typed, logic [31:0] typed);
    typed_pending = has_typed;
    typed_value = typed;
    for (int i = 0; i < s.len(); i++) send_char(s[i], i == s.len() - 1);
  endtask

  task automatic write_cfg(gcwp_pkg::cfg_t c);
    logic [3:0] vals[8];
    vals = '{c.frac_x, c.frac_y, c.len_x, c.len_y, 4'(c.metric), 4'(c.otz),
             4'(c.rel), 4'(c.exc)};
    for (int i = 0; i < 8; i++) begin
      cfg_we_i   <= 1'b1;
      cfg_idx_i  <= 4'(i);
      cfg_data_i <= vals[i];
      @(posedge clk_i);
    end
    cfg_we_i <= 1'b0;
    cfg = c;
  endtask

  function automatic logic [7:0] pick_letter();
    case ($urandom_range(0, 4))
      0: return "X";
      1: return "Y";
      2: return "A";
      3: return "I";
      default: return "J";
    endcase
  endfunction

  task automatic random_sentence();
    int  nw, nd, pt;
    logic [7:0] seps[6];
    seps = '{"*", " ", "D", "\n", "x", ","};
    if ($urandom_range(0, 7) == 0) begin
      nd = $urandom_range(1, 6);
      for (int i = 0; i < nd; i++) send_char(8'($urandom_range(0, 255)), i == nd - 1);
      return;
    end
    nw = $urandom_range(1, 4);
    for (int w = 0; w < nw; w++) begin
      send_char(pick_letter(), 1'b0);
      case ($urandom_range(0, 3))
        0: send_char("-", 1'b0);
        1: send_char("+", 1'b0);
        default: ;
      endcase
      nd = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 15) : $urandom_range(0, 8);
      pt = $urandom_range(0, nd + 3);
      for (int i = 0; i <= nd; i++) begin
        if (i == pt) send_char(".", 1'b0);
        if ($urandom_range(0, 19) == 0) send_char(($urandom_range(0, 1) != 0) ? "-" : ".", 1'b0);
        if (i < nd) send_char("0" + 8'($urandom_range(0, 9)), 1'b0);
      end
      if ($urandom_range(0, 3) == 0) send_char(seps[$urandom_range(0, 5)], 1'b0);
    end
    send_char(($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255)) : "*", 1'b1);
  endtask

  task automatic check_word(gcwp_pkg::out_item_t got);
    gcwp_pkg::out_item_t want;
    if (words_due.size() == 0) begin
      $error("unexpected transaction: word_axis %0d value %0d", got.word_axis,
             got.word_value);
      errors++;
      return;
    end
    want = words_due.pop_front();
    if (got.word_axis !== want.word_axis) begin
      $error("word_axis: expected %0d, got %0d", want.word_axis, got.word_axis);
      errors++;
    end
    if (got.word_value !== want.word_value) begin
      $error("word_value: expected %0d, got %0d", want.word_value, got.word_value);
      errors++;
    end
    if (got.pos_x !== want.pos_x) begin
      $error("pos_x: expected %0d, got %0d", want.pos_x, got.pos_x);
      errors++;
    end
    if (got.pos_y !== want.pos_y) begin
      $error("pos_y: expected %0d, got %0d", want.pos_y, got.pos_y);
      errors++;
    end
    if (got.center_x !== want.center_x) begin
      $error("center_x: expected %0d, got %0d", want.center_x, got.center_x);
      errors++;
    end
    if (got.center_y !== want.center_y) begin
      $error("center_y: expected %0d, got %0d", want.center_y, got.center_y);
      errors++;
    end
    if (got.arc_radius !== want.arc_radius) begin
      $error("arc_radius: expected %0d, got %0d", want.arc_radius, got.arc_radius);
      errors++;
    end
    if (got.arc_kind !== want.arc_kind) begin
      $error("arc_kind: expected %0d, got %0d", want.arc_kind, got.arc_kind);
      errors++;
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) check_word(out_item_o);
  end

  // receiver stalls
  int stall_left = 0;
  always @(posedge clk_i) begin
    if (stall_left > 0) begin
      out_ready_i <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      out_ready_i <= 1'b1;
      if (!quiet && $urandom_range(0, 5) == 0)
        stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60)
                                                  : $urandom_range(1, 3);
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("Mismatches found");
      $finish;
    end
  end

  typedef struct {
    string       text;
    bit          has_typed;
    logic [31:0] value;
  } text_row_t;

  text_row_t directed[] = '{
    '{"X1000*", 1'b1, 32'sd254000},
    '{"X-.5Y2", 1'b1, -32'sd1270000},
    '{"Y99999999999999*", 1'b1, 32'sd2147483647},
    '{"X-999999999999*", 1'b1, 32'h8000_0000},
    '{"I5J", 1'b1, 32'sd1270},
    '{"X-*", 1'b1, 32'sd0},
    '{"X-0 ", 1'b1, 32'sd0},
    '{"A+-1.2.3-x", 1'b0, 32'sd0},
    '{"IJ7", 1'b0, 32'sd0},
    '{"5X", 1'b0, 32'sd0}
  };

  gcwp_pkg::cfg_t settings[] = '{
    '{4'd4, 4'd4, 4'd6, 4'd6, 1'b0, 1'b0, 1'b0, 1'b0},
    '{4'd0, 4'd0, 4'd1, 4'd1, 1'b1, 1'b1, 1'b1, 1'b1},
    '{4'd8, 4'd8, 4'd12, 4'd12, 1'b0, 1'b1, 1'b0, 1'b1},
    '{4'd15, 4'd15, 4'd15, 4'd0, 1'b1, 1'b1, 1'b1, 1'b0},
    '{4'd3, 4'd5, 4'd4, 4'd7, 1'b1, 1'b0, 1'b1, 1'b1},
    '{4'd2, 4'd6, 4'd0, 4'd9, 1'b0, 1'b1, 1'b0, 1'b1}
  };

  initial begin
    cfg = settings[0];
    quiet = 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (settings[p]) begin
      write_cfg(settings[p]);
      quiet = (p == 2);
      if (p == 0) begin
        foreach (directed[i]) send_text(directed[i].text, directed[i].has_typed,
                                        directed[i].value);
      end
      for (int n = 0; n < 5; n++) random_sentence();
      in_valid_i <= 1'b0;
      wait (words_due.size() == 0);
      repeat (100) @(posedge clk_i);
    end
    repeat (200) @(posedge clk_i);
    if (errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/gcwp_pkg.sv
rtl/gcwp_front.sv
rtl/gcwp_queue.sv
rtl/gcwp_back.sv
rtl/gerber_coordinate_word_parser_top.sv
verif/testbench.sv
